// ----- rtl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers; defining ASSERT_OFF removes them.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// Property must hold at every rising edge outside reset.
`define ASSERT_CLK(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed");

// Expression must never be true outside reset.
`define ASSERT_NEVER(lbl, clk, rst_n, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
    else $error("forbidden condition seen");

`else

`define ASSERT_CLK(lbl, clk, rst_n, prop)
`define ASSERT_NEVER(lbl, clk, rst_n, expr)

`endif

`endif

// ----- rtl/hps_pkg.sv -----
// ----------------------------------------------------------------------------
// hps_pkg
// Widths, codes and state encoding for the Hamiltonian path search block.
// ----------------------------------------------------------------------------
package hps_pkg;

  // Field widths of the stream words.
  localparam int MODE_W      = 2;
  localparam int VTX_W       = 4;
  localparam int CNT_W       = 5;
  localparam int IN_TDATA_W  = 16;
  localparam int OUT_TDATA_W = 8;

  // Default sizes of the graph store.
  localparam int DEF_MAX_VERTS  = 16;
  localparam int DEF_MAX_DEGREE = 16;

  // Operation codes carried in the mode field.
  typedef enum logic [MODE_W-1:0] {
    MODE_CLEAR  = 2'd0,
    MODE_APPEND = 2'd1,
    MODE_SEARCH = 2'd2,
    MODE_NONE   = 2'd3
  } mode_t;

  // Sequencer states.
  typedef enum logic [3:0] {
    S_IDLE,
    S_APPEND,
    S_START,
    S_DEG,
    S_CHECK,
    S_NBR,
    S_POP,
    S_NONE,
    S_EMIT_RD,
    S_EMIT_WR
  } state_t;

endpackage

// ----- rtl/hamiltonian_path_search_top.sv -----
// ----------------------------------------------------------------------------
// hamiltonian_path_search_top
// Directed graph store with a depth-first backtracking Hamiltonian path search.
//
// Channel   Direction  Handshake          Contents
// in_*      slave      tvalid/tready      command word: mode, edge or count
// out_*     master     tvalid/tready      path word, tlast on the final word
//
// Clear empties every list; an edge append reads the degree, then writes.
// A search opens each start vertex with a degree read, tries each
// neighbour with a neighbour read and backtracks with a stack read, as
// the neighbour, degree and stack memories have registered reads; emitting
// a path reads one stack frame per word, then sends the top as the final
// word. Reset is synchronous and active low and empties every list at once.
// A stalled output holds its word; a new command is taken while the final
// word still waits to be accepted.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module hamiltonian_path_search_top #(
  parameter int MAX_VERTS  = hps_pkg::DEF_MAX_VERTS,
  parameter int MAX_DEGREE = hps_pkg::DEF_MAX_DEGREE
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // Fields from bit 0: mode[1:0], vertex[5:2], neighbor[9:6], vertex_count[14:10].
  input  logic [hps_pkg::IN_TDATA_W-1:0]  in_tdata,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // Fields from bit 0: found[0], path_vertex[4:1].
  output logic [hps_pkg::OUT_TDATA_W-1:0] out_tdata,
  output logic                            out_tlast
);

  import hps_pkg::*;

  localparam int ROW_W    = $clog2(MAX_VERTS);
  localparam int XW       = (ROW_W > VTX_W) ? ROW_W : VTX_W;
  localparam int NW       = ($clog2(MAX_VERTS + 1) > CNT_W) ? $clog2(MAX_VERTS + 1) : CNT_W;
  localparam int DEG_W    = $clog2(MAX_DEGREE + 1);
  localparam int NBR_DEPTH = MAX_VERTS * MAX_DEGREE;
  localparam int NA_W     = $clog2(NBR_DEPTH);

  typedef struct packed {
    logic [XW-1:0]    vtx;
    logic [DEG_W-1:0] slot;
    logic [DEG_W-1:0] deg;
  } stk_ent_t;

  // Row of a vertex in the per-vertex stores.
  function automatic logic [ROW_W-1:0] row_of(input logic [XW-1:0] x);
    return x[ROW_W-1:0];
  endfunction

  // Address of one slot of one neighbour list.
  function automatic logic [NA_W-1:0] nbr_addr(input logic [XW-1:0] x,
                                               input logic [DEG_W-1:0] s);
    return NA_W'(row_of(x)) * NA_W'(MAX_DEGREE) + NA_W'(s);
  endfunction

  // Input word fields.
  logic [MODE_W-1:0] in_mode;
  logic [VTX_W-1:0]  in_vertex;
  logic [VTX_W-1:0]  in_neighbor;
  logic [CNT_W-1:0]  in_count;
  logic              in_acc;

  assign in_mode     = in_tdata[1:0];
  assign in_vertex   = in_tdata[5:2];
  assign in_neighbor = in_tdata[9:6];
  assign in_count    = in_tdata[14:10];
  assign in_acc      = in_tvalid && in_tready;

  // Control and payload registers.
  state_t           state_r, state_nxt;
  logic [NW-1:0]    d_r, d_nxt;
  logic [NW-1:0]    n_r, n_nxt;
  logic [NW-1:0]    start_r, start_nxt;
  logic [NW-1:0]    k_r, k_nxt;
  logic [XW-1:0]    top_r, top_nxt;
  logic [DEG_W-1:0] slot_r, slot_nxt;
  logic [DEG_W-1:0] tdeg_r, tdeg_nxt;
  logic [XW-1:0]    v_r, v_nxt;
  logic [VTX_W-1:0] w_r, w_nxt;
  logic [MAX_VERTS-1:0] vis_r, vis_nxt;
  logic [MAX_VERTS-1:0] deg_vld_r;
  logic             out_valid_r, out_valid_nxt;
  logic             out_found_r, out_found_nxt;
  logic [VTX_W-1:0] out_vtx_r, out_vtx_nxt;
  logic             out_last_r, out_last_nxt;

  // Memories and their ports.
  logic [VTX_W-1:0] nbr_mem [NBR_DEPTH];
  logic             nbr_we, nbr_re;
  logic [NA_W-1:0]  nbr_waddr, nbr_raddr;
  logic [VTX_W-1:0] nbr_rd_r;

  logic [DEG_W-1:0] deg_mem [MAX_VERTS];
  logic             deg_we, deg_re, deg_clr;
  logic [ROW_W-1:0] deg_waddr, deg_raddr;
  logic [DEG_W-1:0] deg_wdata, deg_rd_r;
  logic             deg_rv_r;

  stk_ent_t         stk_mem [MAX_VERTS];
  logic             stk_we, stk_re;
  logic [ROW_W-1:0] stk_waddr, stk_raddr;
  stk_ent_t         stk_wdata, stk_rd_r;

  // Derived values.
  logic [DEG_W-1:0] deg_eff;
  logic [XW-1:0]    u_x;
  logic             u_ok;
  logic             out_free;
  logic [NW-1:0]    n_sat;

  assign deg_eff  = deg_rv_r ? deg_rd_r : '0;
  assign u_x      = XW'(nbr_rd_r);
  assign u_ok     = (NW'(nbr_rd_r) < n_r) && !vis_r[row_of(u_x)];
  assign out_free = !out_valid_r || out_tready;
  assign n_sat    = (int'(in_count) > MAX_VERTS) ? NW'(MAX_VERTS) : NW'(in_count);

  // Neighbour list memory.
  always_ff @(posedge clk) begin
    if (nbr_we) begin
      nbr_mem[nbr_waddr] <= w_r;
    end
    if (nbr_re) begin
      nbr_rd_r <= nbr_mem[nbr_raddr];
    end
  end

  // Degree memory; an entry without its valid bit reads as zero.
  always_ff @(posedge clk) begin
    if (deg_we) begin
      deg_mem[deg_waddr] <= deg_wdata;
    end
    if (deg_re) begin
      deg_rd_r <= deg_mem[deg_raddr];
      deg_rv_r <= deg_vld_r[deg_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      deg_vld_r <= '0;
    end else if (deg_clr) begin
      deg_vld_r <= '0;
    end else if (deg_we) begin
      deg_vld_r[deg_waddr] <= 1'b1;
    end
  end

  // Search stack memory: one frame per level below the current top.
  always_ff @(posedge clk) begin
    if (stk_we) begin
      stk_mem[stk_waddr] <= stk_wdata;
    end
    if (stk_re) begin
      stk_rd_r <= stk_mem[stk_raddr];
    end
  end

  // State and control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      vis_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      vis_r       <= vis_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    d_r         <= d_nxt;
    n_r         <= n_nxt;
    start_r     <= start_nxt;
    k_r         <= k_nxt;
    top_r       <= top_nxt;
    slot_r      <= slot_nxt;
    tdeg_r      <= tdeg_nxt;
    v_r         <= v_nxt;
    w_r         <= w_nxt;
    out_found_r <= out_found_nxt;
    out_vtx_r   <= out_vtx_nxt;
    out_last_r  <= out_last_nxt;
  end

  // Sequencer: next state, memory controls and output word.
  always_comb begin
    state_nxt     = state_r;
    d_nxt         = d_r;
    n_nxt         = n_r;
    start_nxt     = start_r;
    k_nxt         = k_r;
    top_nxt       = top_r;
    slot_nxt      = slot_r;
    tdeg_nxt      = tdeg_r;
    v_nxt         = v_r;
    w_nxt         = w_r;
    vis_nxt       = vis_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_found_nxt = out_found_r;
    out_vtx_nxt   = out_vtx_r;
    out_last_nxt  = out_last_r;
    in_tready     = 1'b0;
    nbr_we        = 1'b0;
    nbr_re        = 1'b0;
    nbr_waddr     = nbr_addr(v_r, deg_eff);
    nbr_raddr     = nbr_addr(top_r, slot_r);
    deg_we        = 1'b0;
    deg_re        = 1'b0;
    deg_clr       = 1'b0;
    deg_waddr     = row_of(v_r);
    deg_wdata     = deg_eff + 1'b1;
    deg_raddr     = row_of(XW'(in_vertex));
    stk_we        = 1'b0;
    stk_re        = 1'b0;
    stk_waddr     = d_r[ROW_W-1:0];
    stk_wdata     = '{vtx: top_r, slot: slot_r, deg: tdeg_r};
    stk_raddr     = k_r[ROW_W-1:0];

    case (state_r)
      S_IDLE: begin
        in_tready = 1'b1;
        if (in_acc) begin
          case (in_mode)
            MODE_CLEAR: begin
              deg_clr = 1'b1;
            end
            MODE_APPEND: begin
              if (int'(in_vertex) < MAX_VERTS) begin
                deg_re    = 1'b1;
                v_nxt     = XW'(in_vertex);
                w_nxt     = in_neighbor;
                state_nxt = S_APPEND;
              end
            end
            MODE_SEARCH: begin
              n_nxt     = n_sat;
              start_nxt = '0;
              state_nxt = S_START;
            end
            default: begin
            end
          endcase
        end
      end

      // Append to the list unless it is already full.
      S_APPEND: begin
        if (deg_eff < DEG_W'(MAX_DEGREE)) begin
          nbr_we = 1'b1;
          deg_we = 1'b1;
        end
        state_nxt = S_IDLE;
      end

      // Open a search from the next start vertex, or give up.
      S_START: begin
        if (start_r == n_r) begin
          state_nxt = S_NONE;
        end else begin
          vis_nxt                       = '0;
          vis_nxt[row_of(XW'(start_r))] = 1'b1;
          d_nxt                         = '0;
          top_nxt                       = XW'(start_r);
          slot_nxt                      = '0;
          deg_re                        = 1'b1;
          deg_raddr                     = row_of(XW'(start_r));
          state_nxt                     = S_DEG;
        end
      end

      S_DEG: begin
        tdeg_nxt  = deg_eff;
        state_nxt = S_CHECK;
      end

      // Path complete, try the next neighbour, or backtrack.
      S_CHECK: begin
        if (d_r + 1'b1 == n_r) begin
          k_nxt     = '0;
          state_nxt = S_EMIT_RD;
        end else if (slot_r < tdeg_r) begin
          nbr_re    = 1'b1;
          slot_nxt  = slot_r + 1'b1;
          state_nxt = S_NBR;
        end else begin
          vis_nxt[row_of(top_r)] = 1'b0;
          if (d_r == '0) begin
            start_nxt = start_r + 1'b1;
            state_nxt = S_START;
          end else begin
            stk_re    = 1'b1;
            stk_raddr = ROW_W'(d_r - 1'b1);
            d_nxt     = d_r - 1'b1;
            state_nxt = S_POP;
          end
        end
      end

      // Descend into the neighbour if it is in range and not yet on the path.
      S_NBR: begin
        if (u_ok) begin
          vis_nxt[row_of(u_x)] = 1'b1;
          stk_we               = 1'b1;
          d_nxt                = d_r + 1'b1;
          top_nxt              = u_x;
          slot_nxt             = '0;
          deg_re               = 1'b1;
          deg_raddr            = row_of(u_x);
          state_nxt            = S_DEG;
        end else begin
          state_nxt = S_CHECK;
        end
      end

      S_POP: begin
        top_nxt   = stk_rd_r.vtx;
        slot_nxt  = stk_rd_r.slot;
        tdeg_nxt  = stk_rd_r.deg;
        state_nxt = S_CHECK;
      end

      // No path: a single empty word.
      S_NONE: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_found_nxt = 1'b0;
          out_vtx_nxt   = '0;
          out_last_nxt  = 1'b1;
          state_nxt     = S_IDLE;
        end
      end

      // Stack frames first, then the current top as the final word.
      S_EMIT_RD: begin
        if (k_r == d_r) begin
          if (out_free) begin
            out_valid_nxt = 1'b1;
            out_found_nxt = 1'b1;
            out_vtx_nxt   = top_r[VTX_W-1:0];
            out_last_nxt  = 1'b1;
            state_nxt     = S_IDLE;
          end
        end else begin
          stk_re    = 1'b1;
          state_nxt = S_EMIT_WR;
        end
      end

      S_EMIT_WR: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_found_nxt = 1'b1;
          out_vtx_nxt   = stk_rd_r.vtx[VTX_W-1:0];
          out_last_nxt  = 1'b0;
          k_nxt         = k_r + 1'b1;
          state_nxt     = S_EMIT_RD;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Output word.
  assign out_tvalid = out_valid_r;
  assign out_tlast  = out_last_r;
  assign out_tdata  = OUT_TDATA_W'({out_vtx_r, out_found_r});

  // Checks on the search state.
  `ASSERT_CLK(a_vis_matches_depth, clk, rst_n,
    (state_r == S_CHECK) |-> ($countones(vis_r) == int'(d_r) + 1))
  `ASSERT_NEVER(a_depth_below_count, clk, rst_n,
    (state_r == S_CHECK) && (d_r >= n_r))
  `ASSERT_CLK(a_emit_full_path, clk, rst_n,
    (state_r == S_EMIT_RD || state_r == S_EMIT_WR) |-> (d_r + 1'b1 == n_r))

endmodule
